/* rtl/core/svm_pkg.sv */
`timescale 1ns / 1ps

package svm_pkg;

	localparam int SVM_STACK_DEPTH   = 256;
	localparam int SVM_PROGRAM_DEPTH = 1024;

	typedef enum logic [3:0] {
		OP_PUSH = 4'd0,
		OP_POP  = 4'd1,
		OP_JNZ  = 4'd2,
		OP_DUP  = 4'd3,
		OP_SWAP = 4'd4,
		OP_ADD  = 4'd5,
		OP_MUL  = 4'd6,
		OP_PRNT = 4'd7,
		OP_JMP  = 4'd8,
		OP_SIZE = 4'd9
	} op_t;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_UNDER = 3'd1,
		ERR_INDEX = 3'd2,
		ERR_OVER  = 3'd3,
		ERR_LABEL = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWAP
	} state_t;

	typedef struct packed {
		logic [3:0]         cmd;
		logic signed [31:0] push_value;
		logic [8:0]         amount;
		logic [10:0]        jump_dest;
		logic               label_known;
	} instr_t;

	typedef struct packed {
		logic [10:0]        next_pc;
		logic               print_valid;
		logic signed [31:0] print_value;
		logic [7:0]         print_position;
		logic [8:0]         depth;
		logic [2:0]         error;
	} result_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic swap_wr;
	} ctrl_cmd_t;

	typedef struct packed {
		logic swap_pending;
	} ctrl_stat_t;

endpackage

/* rtl/core/svm_ctrl.sv */
`timescale 1ns / 1ps

module svm_ctrl
	import svm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd,
	output logic       busy
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				state_nxt = stat.swap_pending ? ST_SWAP : ST_IDLE;
			end
			ST_SWAP: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.accept = start;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_SWAP: begin
				cmd.swap_wr = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

/* rtl/core/svm_dpath.sv */
`timescale 1ns / 1ps

module svm_dpath
	import svm_pkg::*;
#(
	parameter int STACK_DEPTH   = SVM_STACK_DEPTH,
	parameter int PROGRAM_DEPTH = SVM_PROGRAM_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  instr_t     instr,
	input  ctrl_cmd_t  cmd,
	output ctrl_stat_t stat,
	output logic       done,
	output result_t    result
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int PW = $clog2(PROGRAM_DEPTH + 1);

	logic [31:0]   mem [STACK_DEPTH];

	logic [DW-1:0] depth_q;
	logic [PW-1:0] pc_q;
	logic          done_q;
	instr_t        op_q;
	logic [31:0]   rd_a_q;
	logic [31:0]   rd_b_q;
	result_t       res_q;

	logic [AW-1:0] raddr_a;
	logic [AW-1:0] raddr_b;

	logic [31:0]   d_ext;
	logic [31:0]   amt;
	logic [31:0]   pc_inc;
	logic [31:0]   dest;
	logic [PW-1:0] npc_inc;
	logic [PW-1:0] npc_dest;
	logic [PW-1:0] npc;
	logic [DW-1:0] d_nxt;
	err_t          err;
	logic          commit;
	logic          do_push;
	logic [31:0]   push_word;
	logic          pvalid;
	logic [31:0]   pvalue;
	logic [7:0]    ppos;
	logic [31:0]   sum;
	logic [31:0]   prod;
	result_t       res_nxt;

	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;

	// dup reads the bottom-based index, everything else reads the top two
	assign raddr_a = (instr.cmd == OP_DUP) ? AW'(instr.amount) : AW'(depth_q - 1'b1);
	assign raddr_b = AW'(depth_q - 2'd2);

	assign sum  = rd_a_q + rd_b_q;
	assign prod = rd_a_q * rd_b_q;

	assign d_ext    = 32'(depth_q);
	assign amt      = 32'(op_q.amount);
	assign pc_inc   = 32'(pc_q) + 32'd1;
	assign dest     = 32'(op_q.jump_dest);
	assign npc_inc  = (pc_inc > 32'(PROGRAM_DEPTH)) ? PW'(PROGRAM_DEPTH) : PW'(pc_inc);
	assign npc_dest = (dest > 32'(PROGRAM_DEPTH)) ? PW'(PROGRAM_DEPTH) : PW'(dest);

	always_comb begin
		err       = ERR_NONE;
		d_nxt     = depth_q;
		npc       = npc_inc;
		pvalid    = 1'b0;
		pvalue    = '0;
		ppos      = '0;
		do_push   = 1'b0;
		push_word = '0;
		unique case (op_q.cmd)
			OP_PUSH: begin
				do_push   = 1'b1;
				push_word = op_q.push_value;
			end
			OP_POP: begin
				if (d_ext == 32'd0 || amt > d_ext) err = ERR_UNDER;
				else d_nxt = DW'(d_ext - amt);
			end
			OP_JNZ: begin
				if (d_ext < 32'd2) err = ERR_UNDER;
				else if (rd_a_q != 32'd0) begin
					if (!op_q.label_known) err = ERR_LABEL;
					else npc = npc_dest;
				end
			end
			OP_DUP: begin
				if (amt >= d_ext) err = ERR_INDEX;
				else begin
					do_push   = 1'b1;
					push_word = rd_a_q;
				end
			end
			OP_SWAP: begin
				if (d_ext < 32'd2) err = ERR_UNDER;
			end
			OP_ADD, OP_MUL: begin
				if (d_ext < 32'd2) err = ERR_UNDER;
				else begin
					do_push   = 1'b1;
					push_word = (op_q.cmd == OP_ADD) ? sum : prod;
				end
			end
			OP_PRNT: begin
				if (d_ext == 32'd0) err = ERR_UNDER;
				else begin
					pvalid = 1'b1;
					pvalue = rd_a_q;
					ppos   = 8'(d_ext - 32'd1);
				end
			end
			OP_JMP: begin
				if (!op_q.label_known) err = ERR_LABEL;
				else npc = npc_dest;
			end
			OP_SIZE: begin
				do_push   = 1'b1;
				push_word = d_ext;
			end
			default: begin
				err = ERR_NONE;
			end
		endcase
		if (err == ERR_NONE && do_push) begin
			if (d_ext >= 32'(STACK_DEPTH)) err = ERR_OVER;
			else d_nxt = DW'(d_ext + 32'd1);
		end
	end

	assign commit = (err == ERR_NONE);
	assign stat.swap_pending = (op_q.cmd == OP_SWAP) && commit;

	always_comb begin
		res_nxt.next_pc        = commit ? 11'(npc) : 11'(pc_q);
		res_nxt.print_valid    = commit & pvalid;
		res_nxt.print_value    = commit ? pvalue : 32'd0;
		res_nxt.print_position = commit ? ppos : 8'd0;
		res_nxt.depth          = commit ? 9'(d_nxt) : 9'(depth_q);
		res_nxt.error          = err;
	end

	// single write port: push in exec, swap takes a second beat for the lower entry
	always_comb begin
		we    = 1'b0;
		waddr = AW'(depth_q);
		wdata = push_word;
		if (cmd.exec && commit && do_push) begin
			we = 1'b1;
		end else if (cmd.exec && stat.swap_pending) begin
			we    = 1'b1;
			waddr = AW'(d_ext - 32'd1);
			wdata = rd_b_q;
		end else if (cmd.swap_wr) begin
			we    = 1'b1;
			waddr = AW'(d_ext - 32'd2);
			wdata = rd_a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= instr;
			rd_a_q <= mem[raddr_a];
			rd_b_q <= mem[raddr_b];
		end
		if (cmd.exec) res_q <= res_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			pc_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cmd.exec && commit) begin
				depth_q <= d_nxt;
				pc_q    <= npc;
			end
			done_q <= (cmd.exec && !stat.swap_pending) || cmd.swap_wr;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

/* rtl/core/stack_vm_execute_top.sv */
// stack machine execute unit: runs one instruction per beat against an on-chip
// operand stack and keeps the program counter.
// command channel: an instruction beat is taken on a rising edge with start high
// and busy low. the instruction fields travel in instr.
// result channel: done is high for exactly one cycle and result holds the beat
// until the next instruction is executed; the receiver has no way to stall it.
// result timing: result is registered at the end of the execute state, and done
// with it, but for swap done is registered at the end of the swap write state.
// a new instruction waits until the previous one is through. the stack memory has
// one write port and a registered read, so the operands are read in the accept
// cycle, the instruction is executed and written back in the next, and swap needs
// a second write beat for the lower entry.
// busy is high while an instruction is in flight; a new one may be taken in the
// same cycle that done is shown.
// errors (underflow, bad dup index, overflow, undefined label) leave stack depth
// and program counter untouched and are reported in result.error.
// reset clears depth, program counter and the state machine; stack contents are
// not cleared, and values read from above the current depth are never used.
`timescale 1ns / 1ps

module stack_vm_execute_top
	import svm_pkg::*;
#(
	parameter int STACK_DEPTH   = SVM_STACK_DEPTH,
	parameter int PROGRAM_DEPTH = SVM_PROGRAM_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  instr_t  instr,
	output logic    busy,
	output logic    done,
	output result_t result
);

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	svm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	svm_dpath #(
		.STACK_DEPTH   (STACK_DEPTH),
		.PROGRAM_DEPTH (PROGRAM_DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted instruction did not raise busy");

	a_print_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.print_valid) |-> (result.error == ERR_NONE))
		else $error("print result carries an error");

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.error != ERR_NONE) |->
		(!result.print_valid && result.print_value == 32'd0 && result.print_position == 8'd0))
		else $error("error result has print data");

endmodule

/* tb/sv/tb_stack_vm_execute_top.sv */
`timescale 1ns / 1ps

module tb_stack_vm_execute_top;
	import svm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1350;
	localparam logic [3:0] OP_UNUSED_LO = 4'd10;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	instr_t instr = '0;
	logic busy;
	logic done;
	result_t result;

	stack_vm_execute_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.instr(instr),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always #2 clk = ~clk;

	// shadow of the machine state, advanced once per accepted beat
	logic [31:0] shadow_stack [SVM_STACK_DEPTH];
	logic [8:0] shadow_depth = '0;
	logic [10:0] shadow_pc = '0;

	result_t pending_results[$];
	int items_sent = 0;
	int results_seen = 0;
	int failures = 0;
	int burst_left = 5;
	int cycles = 0;
	int err_tally [5] = '{default: 0};
	int prints_seen = 0;
	int full_hits = 0;

	function automatic result_t execute_instr(instr_t i);
		result_t r;
		logic [8:0] d;
		logic [10:0] dest;
		logic [10:0] npc;
		logic [31:0] word;
		logic [31:0] a;
		logic [31:0] b;
		logic pushing;
		err_t e;
		r = '0;
		d = shadow_depth;
		e = ERR_NONE;
		pushing = 1'b0;
		word = '0;
		dest = (i.jump_dest > SVM_PROGRAM_DEPTH) ? 11'(SVM_PROGRAM_DEPTH) : i.jump_dest;
		npc = (shadow_pc >= SVM_PROGRAM_DEPTH) ? 11'(SVM_PROGRAM_DEPTH) : shadow_pc + 11'd1;
		case (i.cmd)
			OP_PUSH: begin
				pushing = 1'b1;
				word = i.push_value;
			end
			OP_POP: begin
				if (d == 0 || i.amount > d) e = ERR_UNDER;
				else d = d - i.amount;
			end
			OP_JNZ: begin
				// label only matters when the branch is taken
				if (d < 2) e = ERR_UNDER;
				else if (shadow_stack[d - 9'd1] != 0) begin
					if (!i.label_known) e = ERR_LABEL;
					else npc = dest;
				end
			end
			OP_DUP: begin
				if (i.amount >= d) e = ERR_INDEX;
				else begin
					pushing = 1'b1;
					word = shadow_stack[i.amount];
				end
			end
			OP_SWAP: begin
				if (d < 2) e = ERR_UNDER;
				else begin
					a = shadow_stack[d - 9'd1];
					shadow_stack[d - 9'd1] = shadow_stack[d - 9'd2];
					shadow_stack[d - 9'd2] = a;
				end
			end
			OP_ADD, OP_MUL: begin
				if (d < 2) e = ERR_UNDER;
				else begin
					a = shadow_stack[d - 9'd1];
					b = shadow_stack[d - 9'd2];
					pushing = 1'b1;
					word = (i.cmd == OP_ADD) ? a + b : a * b;
				end
			end
			OP_PRNT: begin
				if (d == 0) e = ERR_UNDER;
				else begin
					r.print_valid = 1'b1;
					r.print_value = shadow_stack[d - 9'd1];
					r.print_position = 8'(d - 9'd1);
				end
			end
			OP_JMP: begin
				if (!i.label_known) e = ERR_LABEL;
				else npc = dest;
			end
			OP_SIZE: begin
				pushing = 1'b1;
				word = 32'(d);
			end
			default: ;
		endcase
		if (e == ERR_NONE && pushing) begin
			if (d >= SVM_STACK_DEPTH) e = ERR_OVER;
			else begin
				shadow_stack[d] = word;
				d = d + 9'd1;
			end
		end
		if (e != ERR_NONE) begin
			npc = shadow_pc;
			r.print_valid = 1'b0;
			r.print_value = '0;
			r.print_position = '0;
			d = shadow_depth;
		end else begin
			shadow_depth = d;
			shadow_pc = npc;
		end
		r.next_pc = npc;
		r.depth = d;
		r.error = e;
		return r;
	endfunction

	function automatic instr_t mk(logic [3:0] cmd, logic [31:0] val, logic [8:0] amt,
			logic [10:0] dest, logic known);
		instr_t i;
		i.cmd = cmd;
		i.push_value = val;
		i.amount = amt;
		i.jump_dest = dest;
		i.label_known = known;
		return i;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// mostly well-formed instructions sized to the current depth, some raw noise
	function automatic instr_t random_instr(logic deep);
		instr_t i;
		int w;
		i = mk(OP_PUSH, pick_value(), 9'($urandom_range(0, 511)),
			11'($urandom_range(0, 1023)), $urandom_range(0, 9) != 0);
		if ($urandom_range(0, 99) < 8) begin
			i.cmd = 4'($urandom_range(0, 15));
			i.amount = 9'($urandom_range(0, 511));
			i.jump_dest = 11'($urandom_range(0, 2047));
			i.label_known = 1'($urandom_range(0, 1));
			return i;
		end
		w = $urandom_range(0, 99);
		if (w < 20) i.cmd = OP_PUSH;
		else if (w < 32) i.cmd = OP_POP;
		else if (w < 40) i.cmd = OP_JNZ;
		else if (w < 50) i.cmd = OP_DUP;
		else if (w < 60) i.cmd = OP_SWAP;
		else if (w < 69) i.cmd = OP_ADD;
		else if (w < 77) i.cmd = OP_MUL;
		else if (w < 87) i.cmd = OP_PRNT;
		else if (w < 93) i.cmd = OP_JMP;
		else i.cmd = OP_SIZE;
		if (i.cmd == OP_POP)
			i.amount = deep ? 9'($urandom_range(0, 2))
				: 9'($urandom_range(0, shadow_depth + 1));
		else if (i.cmd == OP_DUP && shadow_depth != 0 && $urandom_range(0, 99) < 85)
			i.amount = 9'($urandom_range(0, shadow_depth - 1));
		return i;
	endfunction

	task automatic send_instr(input instr_t i);
		start <= 1'b1;
		instr <= i;
		do @(posedge clk); while (busy);
		pending_results.insert(pending_results.size(), execute_instr(i));
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			failures++;
			if (failures <= 10)
				$display("result %0d %s: expected %h, got %h", results_seen, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10) $display("result beat with nothing pending: %p", result);
			end else begin
				want = pending_results.pop_front();
				check_field("next_pc", want.next_pc, result.next_pc);
				check_field("print_valid", want.print_valid, result.print_valid);
				check_field("print_value", want.print_value, result.print_value);
				check_field("print_position", want.print_position, result.print_position);
				check_field("depth", want.depth, result.depth);
				check_field("error", want.error, result.error);
				if (want.error <= ERR_LABEL) err_tally[want.error]++;
				if (want.print_valid) prints_seen++;
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic test_empty_stack();
		send_instr(mk(OP_POP, '0, 9'd0, '0, 1'b1));
		send_instr(mk(OP_POP, '0, 9'd1, '0, 1'b1));
		send_instr(mk(OP_PRNT, '0, '0, '0, 1'b1));
		send_instr(mk(OP_SWAP, '0, '0, '0, 1'b1));
		send_instr(mk(OP_ADD, '0, '0, '0, 1'b1));
		send_instr(mk(OP_MUL, '0, '0, '0, 1'b1));
		send_instr(mk(OP_JNZ, '0, '0, 11'd5, 1'b1));
		send_instr(mk(OP_DUP, '0, 9'd0, '0, 1'b1));
		send_instr(mk(OP_SIZE, '0, '0, '0, 1'b1));
		send_instr(mk(OP_SWAP, '0, '0, '0, 1'b1));
		send_instr(mk(OP_JNZ, '0, '0, 11'd5, 1'b1));
		send_instr(mk(OP_POP, '0, 9'd2, '0, 1'b1));
	endtask

	task automatic test_values_and_arith();
		send_instr(mk(OP_PUSH, 32'h7fff_ffff, 9'h1ff, 11'h7ff, 1'b0));
		send_instr(mk(OP_PUSH, 32'h8000_0000, '0, '0, 1'b1));
		send_instr(mk(OP_ADD, '0, '0, '0, 1'b1));
		send_instr(mk(OP_MUL, '0, '0, '0, 1'b1));
		send_instr(mk(OP_SWAP, '0, '0, '0, 1'b1));
		send_instr(mk(OP_PRNT, '0, '0, '0, 1'b1));
		send_instr(mk(OP_DUP, '0, 9'd0, '0, 1'b1));
		send_instr(mk(OP_DUP, '0, 9'h1ff, '0, 1'b1));
		send_instr(mk(OP_POP, '0, 9'd0, '0, 1'b1));
		send_instr(mk(OP_POP, '0, 9'd3, '0, 1'b1));
		send_instr(mk(OP_PRNT, '0, '0, '0, 1'b1));
	endtask

	task automatic test_jumps_and_pc();
		send_instr(mk(OP_PUSH, 32'h0, '0, '0, 1'b1));
		send_instr(mk(OP_PUSH, 32'h0, '0, '0, 1'b1));
		// zero on top: not taken, so the unknown label goes unnoticed
		send_instr(mk(OP_JNZ, '0, '0, 11'd100, 1'b0));
		send_instr(mk(OP_PUSH, 32'hffff_ffff, '0, '0, 1'b1));
		send_instr(mk(OP_JNZ, '0, '0, 11'd100, 1'b0));
		send_instr(mk(OP_JNZ, '0, '0, 11'h7ff, 1'b1));
		send_instr(mk(OP_UNUSED_LO, '0, '0, '0, 1'b1));
		send_instr(mk(OP_UNUSED_HI, 32'hffff_ffff, 9'h1ff, 11'h7ff, 1'b1));
		send_instr(mk(OP_JMP, '0, '0, 11'd3, 1'b0));
		send_instr(mk(OP_JMP, '0, '0, 11'd1023, 1'b1));
		send_instr(mk(OP_SIZE, '0, '0, '0, 1'b1));
		send_instr(mk(OP_SIZE, '0, '0, '0, 1'b1));
		send_instr(mk(OP_JMP, '0, '0, 11'd0, 1'b1));
	endtask

	task automatic test_stack_full();
		while (shadow_depth < SVM_STACK_DEPTH)
			send_instr(mk(OP_PUSH, pick_value(), '0, '0, 1'b1));
		send_instr(mk(OP_PUSH, 32'h1234_5678, '0, '0, 1'b1));
		send_instr(mk(OP_SIZE, '0, '0, '0, 1'b1));
		send_instr(mk(OP_DUP, '0, 9'd255, '0, 1'b1));
		send_instr(mk(OP_ADD, '0, '0, '0, 1'b1));
		send_instr(mk(OP_MUL, '0, '0, '0, 1'b1));
		send_instr(mk(OP_PRNT, '0, '0, '0, 1'b1));
		send_instr(mk(OP_DUP, '0, 9'd256, '0, 1'b1));
		send_instr(mk(OP_SWAP, '0, '0, '0, 1'b1));
		send_instr(mk(OP_POP, '0, 9'd256, '0, 1'b1));
		send_instr(mk(OP_POP, '0, 9'd0, '0, 1'b1));
	endtask

	task automatic test_random_programs();
		logic deep;
		deep = 1'b0;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			// alternate between climbing toward a full stack and staying shallow
			if (k % 150 == 0) deep = ~deep;
			if (shadow_depth == SVM_STACK_DEPTH) full_hits++;
			send_instr(random_instr(deep));
		end
	endtask

	initial begin
		foreach (shadow_stack[n]) shadow_stack[n] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_stack();
		test_values_and_arith();
		test_jumps_and_pc();
		test_stack_full();
		test_random_programs();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("%0d instructions, %0d results checked, %0d prints, full stack seen %0d times",
			items_sent, results_seen, prints_seen, full_hits);
		$display("errors: underflow %0d, dup index %0d, overflow %0d, label %0d; %0d mismatches",
			err_tally[ERR_UNDER], err_tally[ERR_INDEX], err_tally[ERR_OVER],
			err_tally[ERR_LABEL], failures);
		if (failures == 0 && pending_results.size() == 0 && results_seen == items_sent)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* stack_vm_execute_top.f */
rtl/core/svm_pkg.sv
rtl/core/svm_ctrl.sv
rtl/core/svm_dpath.sv
rtl/core/stack_vm_execute_top.sv
tb/sv/tb_stack_vm_execute_top.sv
